// ===== src/voxel_face_visibility_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Voxel face visibility unit: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VOXEL_FACE_VISIBILITY_UNIT_DEFINES_SVH
`define VOXEL_FACE_VISIBILITY_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define VFV_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent
`define VFV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/vfv_pkg.sv =====
// ----------------------------------------------------------------------------
// Voxel face visibility package
// Beat types, command and register codes, default chunk dimensions.
// ----------------------------------------------------------------------------
package vfv_pkg;

  // Default chunk dimensions
  localparam int SIZE_XY_DEF = 16;
  localparam int HEIGHT_DEF  = 128;

  // Field widths
  localparam int CELL_W    = 4;
  localparam int LEVEL_W   = 7;
  localparam int OFF_W     = 16;
  localparam int WORLD_W   = 20;
  localparam int MASK_W    = 6;
  localparam int CFG_IDX_W = 2;

  // Command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_FILL  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  // Configuration register indices
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z = 2'd1;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [CELL_W-1:0]  cell_x;
    logic [CELL_W-1:0]  cell_z;
    logic [LEVEL_W-1:0] cell_level;
    logic               solid_in;
    logic [LEVEL_W-1:0] column_height;
  } vfv_in_t;

  typedef struct packed {
    logic                      is_solid;
    logic [MASK_W-1:0]         face_mask;
    logic signed [WORLD_W-1:0] world_x;
    logic [LEVEL_W-1:0]        world_level;
    logic signed [WORLD_W-1:0] world_z;
  } vfv_out_t;

endpackage

// ===== src/vfv_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module vfv_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/voxel_face_visibility_unit.sv =====
// The single read port of the column memory sets the rate: for a query the voxel's
//   own column and four neighbour columns are read one per cycle.
// Reset (synchronous, rst_n low): all column valid bits clear together, so the
//   chunk reads as all air at once; both offsets return to zero.
// ----------------------------------------------------------------------------
// Voxel face visibility unit
// Keeps a chunk of solid/air voxels as columns in memory, applies voxel writes
// and column fills, and answers face-exposure queries.
// ----------------------------------------------------------------------------
module voxel_face_visibility_unit #(
  parameter int SIZE_XY = vfv_pkg::SIZE_XY_DEF,
  parameter int HEIGHT  = vfv_pkg::HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  vfv_pkg::vfv_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output vfv_pkg::vfv_out_t                   out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vfv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vfv_pkg::OFF_W-1:0]           cfg_data
);
  import vfv_pkg::*;

  localparam int DEPTH = SIZE_XY * SIZE_XY;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = $clog2(HEIGHT);
  localparam int HALF  = HEIGHT / 2;

  // Probe order: own column, then x-1, x+1, z-1, z+1
  localparam logic [2:0] PRB_SELF  = 3'd0;
  localparam logic [2:0] PRB_XM    = 3'd1;
  localparam logic [2:0] PRB_XP    = 3'd2;
  localparam logic [2:0] PRB_ZM    = 3'd3;
  localparam logic [2:0] PRB_ZP    = 3'd4;
  localparam logic [2:0] PRB_COUNT = 3'd5;

  typedef enum logic [1:0] {S_IDLE, S_PROBE, S_EMIT} state_t;

  state_t                     state_r, state_nxt;
  logic [2:0]                 iss_r, iss_nxt;
  vfv_in_t                    item_r, item_nxt;
  logic                       pin_r, pin_nxt;
  logic                       rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]              self_addr_r, self_addr_nxt;
  logic                       solid_r, solid_nxt;
  logic [MASK_W-1:0]          mask_r, mask_nxt;
  logic                       out_valid_r, out_valid_nxt;
  vfv_out_t                   out_data_r, out_data_nxt;
  logic [OFF_W-1:0]           off_x_r, off_x_nxt;
  logic [OFF_W-1:0]           off_z_r, off_z_nxt;
  logic [DEPTH-1:0]           col_vld_r, col_vld_nxt;

  logic [CELL_W:0]            px;
  logic [CELL_W:0]            pz;
  logic                       edge_out;
  logic                       pin;
  logic [AW-1:0]              addr;
  logic [2:0]                 ev;
  logic [HEIGHT-1:0]          rd_data;
  logic [HEIGHT-1:0]          col;
  logic [HEIGHT-1:0]          fill_col;
  logic [HEIGHT-1:0]          wr_col;
  logic [LW-1:0]              lvi;
  logic [LW-1:0]              lvi_dn;
  logic [LW-1:0]              lvi_up;
  logic                       lv_ok;
  logic                       nb_exp;
  logic                       we;
  logic [HEIGHT-1:0]          wdata;
  logic signed [WORLD_W-1:0]  offx_ext;
  logic signed [WORLD_W-1:0]  offz_ext;

  // Column memory
  vfv_ram #(
    .WIDTH(HEIGHT),
    .DEPTH(DEPTH)
  ) u_vfv_ram (
    .clk  (clk),
    .we   (we),
    .waddr(self_addr_r),
    .wdata(wdata),
    .raddr(addr),
    .rdata(rd_data)
  );

  // Probe coordinates and column address for the probe being issued
  always_comb begin
    px       = {1'b0, item_r.cell_x};
    pz       = {1'b0, item_r.cell_z};
    edge_out = 1'b0;
    case (iss_r)
      PRB_XM: begin
        px       = px - 1'b1;
        edge_out = (item_r.cell_x == '0);
      end
      PRB_XP: px = px + 1'b1;
      PRB_ZM: begin
        pz       = pz - 1'b1;
        edge_out = (item_r.cell_z == '0);
      end
      PRB_ZP: pz = pz + 1'b1;
      default: ;
    endcase
    pin  = !edge_out && (int'(px) < SIZE_XY) && (int'(pz) < SIZE_XY);
    addr = pin ? AW'(int'(px) * SIZE_XY + int'(pz)) : '0;
  end

  // Column word as read, never-written columns read as air
  assign col    = rd_vld_r ? rd_data : '0;
  assign lvi    = LW'(item_r.cell_level);
  assign lvi_dn = lvi - LW'(1);
  assign lvi_up = lvi + LW'(1);
  assign lv_ok  = int'(item_r.cell_level) < HEIGHT;
  assign ev     = iss_r - 3'd1;
  assign nb_exp = !pin_r || !lv_ok || !col[lvi];

  // Fill: solid below the height, air above the half level, other levels kept
  always_comb begin
    for (int k = 0; k < HEIGHT; k++) begin
      if (k > HALF) begin
        fill_col[k] = 1'b0;
      end else if (k < int'(item_r.column_height)) begin
        fill_col[k] = 1'b1;
      end else begin
        fill_col[k] = col[k];
      end
    end
  end

  // Write: replace one level of the column
  always_comb begin
    wr_col      = col;
    wr_col[lvi] = item_r.solid_in;
  end

  assign offx_ext = WORLD_W'(signed'(off_x_r));
  assign offz_ext = WORLD_W'(signed'(off_z_r));

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    iss_nxt       = iss_r;
    item_nxt      = item_r;
    pin_nxt       = pin;
    rd_vld_nxt    = pin && col_vld_r[addr];
    self_addr_nxt = self_addr_r;
    solid_nxt     = solid_r;
    mask_nxt      = mask_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    off_x_nxt     = off_x_r;
    off_z_nxt     = off_z_r;
    col_vld_nxt   = col_vld_r;
    we            = 1'b0;
    wdata         = wr_col;

    // Drop a result beat once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // Configuration writes
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_OFFSET_X: off_x_nxt = cfg_data;
        CFG_OFFSET_Z: off_z_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          iss_nxt  = PRB_SELF;
          unique case (in_data.cmd) inside
            CMD_WRITE, CMD_FILL, CMD_QUERY: state_nxt = S_PROBE;
            default: ;
          endcase
        end
      end

      S_PROBE: begin
        if (iss_r == PRB_SELF) begin
          self_addr_nxt = addr;
        end
        if (iss_r != PRB_SELF) begin
          if (ev == PRB_SELF) begin
            // Own column: solid bit and vertical neighbours
            solid_nxt     = pin_r && lv_ok && col[lvi];
            mask_nxt[3:0] = '0;
            mask_nxt[4]   = (item_r.cell_level == '0) || !col[lvi_dn];
            mask_nxt[5]   = (int'(item_r.cell_level) + 1 >= HEIGHT) || !col[lvi_up];
            iss_nxt       = iss_r + 3'd1;
            unique case (item_r.cmd)
              CMD_WRITE: begin
                we        = pin_r && lv_ok;
                wdata     = wr_col;
                state_nxt = S_IDLE;
              end
              CMD_FILL: begin
                we        = pin_r;
                wdata     = fill_col;
                state_nxt = S_IDLE;
              end
              default: ;
            endcase
            if (we) begin
              col_vld_nxt[self_addr_r] = 1'b1;
            end
          end else begin
            // Horizontal neighbour: exposed if outside or air
            case (ev)
              PRB_XM:  mask_nxt[0] = nb_exp;
              PRB_XP:  mask_nxt[1] = nb_exp;
              PRB_ZM:  mask_nxt[2] = nb_exp;
              default: mask_nxt[3] = nb_exp;
            endcase
            if (iss_r == PRB_COUNT) begin
              state_nxt = S_EMIT;
            end else begin
              iss_nxt = iss_r + 3'd1;
            end
          end
        end else begin
          iss_nxt = iss_r + 3'd1;
        end
      end

      S_EMIT: begin
        // Load the result beat once the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.is_solid    = solid_r;
          out_data_nxt.face_mask   = solid_r ? mask_r : '0;
          out_data_nxt.world_x     = offx_ext * WORLD_W'(SIZE_XY)
                                     + WORLD_W'(item_r.cell_x);
          out_data_nxt.world_level = item_r.cell_level;
          out_data_nxt.world_z     = offz_ext * WORLD_W'(SIZE_XY)
                                     + WORLD_W'(item_r.cell_z);
          state_nxt                = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iss_r       <= PRB_SELF;
      pin_r       <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
      off_x_r     <= '0;
      off_z_r     <= '0;
      col_vld_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      iss_r       <= iss_nxt;
      pin_r       <= pin_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
      off_x_r     <= off_x_nxt;
      off_z_r     <= off_z_nxt;
      col_vld_r   <= col_vld_nxt;
    end
    item_r      <= item_nxt;
    self_addr_r <= self_addr_nxt;
    solid_r     <= solid_nxt;
    mask_r      <= mask_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

endmodule

// ===== src/vfv_checker.sv =====
// ----------------------------------------------------------------------------
// Voxel face visibility checker
// Port-level assertions on the top level, attached by bind.
// ----------------------------------------------------------------------------
`include "voxel_face_visibility_unit_defines.svh"

module vfv_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input vfv_pkg::vfv_in_t              in_data,
  input logic                          out_valid,
  input logic                          out_ready,
  input vfv_pkg::vfv_out_t             out_data
);
  import vfv_pkg::*;

  // Hold a stalled result beat
  `VFV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result beat changed while stalled")

  // Busy after taking a real command
  `VFV_ASSERT_NEXT(a_busy_after_cmd, in_valid && in_ready && (in_data.cmd == CMD_WRITE || in_data.cmd == CMD_FILL || in_data.cmd == CMD_QUERY), !in_ready, "input taken again without processing")

  // Writes, fills and unused codes raise no result
  `VFV_ASSERT_NEXT(a_no_spurious, in_valid && in_ready && in_data.cmd != CMD_QUERY, !$rose(out_valid), "result raised by a non-query beat")

  // Air voxels expose no faces
  `VFV_ASSERT_SAME(a_air_mask, out_valid && !out_data.is_solid, out_data.face_mask == '0, "air voxel with exposed faces")

endmodule

bind voxel_face_visibility_unit vfv_checker u_vfv_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
